// ----- src/sbc_pkg.sv -----
`default_nettype none
package sbc_pkg;

    // Default for the largest sprite or framebuffer side.
    localparam int MAX_SIDE_DEF = 1024;

    // Fixed field widths.
    localparam int SIZE_W  = 11;
    localparam int COORD_W = 16;
    localparam int ORG_W   = 17;
    localparam int POS_W   = 19;
    localparam int PIX_W   = 8;
    localparam int ADDR_W  = 20;

    // Queue between front and back.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;

    // Configuration port.
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [2:0] {
        REG_SRC_WIDTH   = 3'd0,
        REG_SRC_HEIGHT  = 3'd1,
        REG_HOTSPOT_X   = 3'd2,
        REG_HOTSPOT_Y   = 3'd3,
        REG_KEY_ENABLE  = 3'd4,
        REG_KEY_COLOR   = 3'd5,
        REG_DEST_WIDTH  = 3'd6,
        REG_DEST_HEIGHT = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [SIZE_W-1:0]         src_width;
        logic [SIZE_W-1:0]         src_height;
        logic signed [COORD_W-1:0] hotspot_x;
        logic signed [COORD_W-1:0] hotspot_y;
        logic                      key_enable;
        logic [PIX_W-1:0]          key_color;
        logic [SIZE_W-1:0]         dest_width;
        logic [SIZE_W-1:0]         dest_height;
    } cfg_t;

    // One placed pixel waiting for the back end.
    typedef struct packed {
        logic signed [POS_W-1:0] dc;
        logic signed [POS_W-1:0] dr;
        logic [PIX_W-1:0]        pix;
        logic                    last;
    } pix_t;

    // A size of zero counts as one, and a size above the cap is clamped to it.
    function automatic logic [SIZE_W-1:0] side_fix(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] cap);
        logic [SIZE_W-1:0] r;
        if (v == '0) begin
            r = SIZE_W'(1);
        end else if (v > cap) begin
            r = cap;
        end else begin
            r = v;
        end
        return r;
    endfunction

    // Clamp to the 17-bit signed origin range.
    function automatic logic signed [ORG_W-1:0] sat_org(input logic signed [POS_W-1:0] v);
        logic signed [ORG_W-1:0] r;
        if (v < -(POS_W'(65536))) begin
            r = {1'b1, {(ORG_W-1){1'b0}}};
        end else if (v > POS_W'(65535)) begin
            r = {1'b0, {(ORG_W-1){1'b1}}};
        end else begin
            r = v[ORG_W-1:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- src/sbc_front.sv -----
`default_nettype none
module sbc_front #(
    parameter int MAX_SIDE = sbc_pkg::MAX_SIDE_DEF
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire sbc_pkg::cfg_t cfg,
    input  wire logic          accept,
    input  wire logic          cmd,
    input  wire logic [15:0]   place_x,
    input  wire logic [15:0]   place_y,
    input  wire logic          mirror_x,
    input  wire logic          mirror_y,
    input  wire logic [7:0]    pixel_value,
    output logic               push,
    output sbc_pkg::pix_t      push_entry
);

    localparam int CW = $clog2(MAX_SIDE);
    localparam int EW = ((CW > sbc_pkg::SIZE_W) ? CW : sbc_pkg::SIZE_W) + 1;
    localparam int OW = sbc_pkg::POS_W - 1;

    logic [CW-1:0] col_reg, col_next;
    logic [CW-1:0] row_reg, row_next;
    logic signed [sbc_pkg::ORG_W-1:0] org_col_reg, org_col_next;
    logic signed [sbc_pkg::ORG_W-1:0] org_row_reg, org_row_next;
    logic flip_h_reg, flip_h_next;
    logic flip_v_reg, flip_v_next;

    logic [EW-1:0] col_inc, row_inc;
    logic          col_wrap, row_wrap;

    logic signed [sbc_pkg::POS_W-1:0] w_s, h_s, col_s, row_s, off_c, off_r;
    logic signed [OW-1:0] offx, offy;
    logic signed [sbc_pkg::POS_W-1:0] org_x_raw, org_y_raw;

    always_comb begin
        col_inc  = EW'(col_reg) + EW'(1);
        row_inc  = EW'(row_reg) + EW'(1);
        col_wrap = col_inc >= EW'(cfg.src_width);
        row_wrap = row_inc >= EW'(cfg.src_height);

        // Mirrored column and row offsets inside the sprite.
        w_s   = $signed({{(sbc_pkg::POS_W-sbc_pkg::SIZE_W){1'b0}}, cfg.src_width});
        h_s   = $signed({{(sbc_pkg::POS_W-sbc_pkg::SIZE_W){1'b0}}, cfg.src_height});
        col_s = $signed({{(sbc_pkg::POS_W-CW){1'b0}}, col_reg});
        row_s = $signed({{(sbc_pkg::POS_W-CW){1'b0}}, row_reg});
        off_c = flip_h_reg ? (w_s - sbc_pkg::POS_W'(1) - col_s) : col_s;
        off_r = flip_v_reg ? (h_s - sbc_pkg::POS_W'(1) - row_s) : row_s;

        push_entry.dc   = sbc_pkg::POS_W'(org_col_reg) + off_c;
        push_entry.dr   = sbc_pkg::POS_W'(org_row_reg) + off_r;
        push_entry.pix  = pixel_value;
        push_entry.last = col_wrap && row_wrap;
        push            = accept && cmd;

        // Origin for a start word: placement minus the (possibly mirrored) hotspot.
        offx = mirror_x ? (OW'(w_s) - OW'(cfg.hotspot_x)) : OW'(cfg.hotspot_x);
        offy = mirror_y ? (OW'(h_s) - OW'(cfg.hotspot_y)) : OW'(cfg.hotspot_y);
        org_x_raw = sbc_pkg::POS_W'($signed(place_x)) - sbc_pkg::POS_W'(offx);
        org_y_raw = sbc_pkg::POS_W'($signed(place_y)) - sbc_pkg::POS_W'(offy);
    end

    always_comb begin
        col_next     = col_reg;
        row_next     = row_reg;
        org_col_next = org_col_reg;
        org_row_next = org_row_reg;
        flip_h_next  = flip_h_reg;
        flip_v_next  = flip_v_reg;
        if (accept && !cmd) begin
            flip_h_next  = mirror_x;
            flip_v_next  = mirror_y;
            org_col_next = sbc_pkg::sat_org(org_x_raw);
            org_row_next = sbc_pkg::sat_org(org_y_raw);
            col_next     = '0;
            row_next     = '0;
        end else if (push) begin
            if (col_wrap) begin
                col_next = '0;
                row_next = row_wrap ? '0 : row_inc[CW-1:0];
            end else begin
                col_next = col_inc[CW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg     <= '0;
            row_reg     <= '0;
            org_col_reg <= '0;
            org_row_reg <= '0;
            flip_h_reg  <= 1'b0;
            flip_v_reg  <= 1'b0;
        end else begin
            col_reg     <= col_next;
            row_reg     <= row_next;
            org_col_reg <= org_col_next;
            org_row_reg <= org_row_next;
            flip_h_reg  <= flip_h_next;
            flip_v_reg  <= flip_v_next;
        end
    end

endmodule
`default_nettype wire

// ----- src/sbc_fifo.sv -----
`default_nettype none
module sbc_fifo (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire sbc_pkg::pix_t push_entry,
    input  wire logic          pop,
    output sbc_pkg::pix_t      head,
    output logic               empty,
    output logic               full
);

    localparam int PW = sbc_pkg::FIFO_PTR_W;
    localparam int CNT_W = PW + 1;

    sbc_pkg::pix_t mem_reg [sbc_pkg::FIFO_DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb begin
        empty = count_reg == '0;
        full  = count_reg == CNT_W'(sbc_pkg::FIFO_DEPTH);
        head  = mem_reg[rd_ptr_reg];

        wr_ptr_next = push ? wr_ptr_reg + PW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

// ----- src/sbc_back.sv -----
`default_nettype none
module sbc_back (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire sbc_pkg::cfg_t cfg,
    input  wire sbc_pkg::pix_t head,
    input  wire logic          empty,
    output logic               pop,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [31:0]        m_tdata,
    output logic               m_tlast
);

    localparam int SW = sbc_pkg::SIZE_W;
    localparam int PROD_W = 2 * SW;

    logic valid_reg, valid_next;
    logic                      we_reg, we_next;
    logic [sbc_pkg::ADDR_W-1:0] addr_reg, addr_next;
    logic [sbc_pkg::PIX_W-1:0]  color_reg, color_next;
    logic                      last_reg, last_next;

    logic signed [sbc_pkg::POS_W-1:0] dw_s, dh_s;
    logic in_frame, keyed;
    logic [PROD_W-1:0] prod, sum;

    always_comb begin
        dw_s   = $signed({{(sbc_pkg::POS_W-SW){1'b0}}, cfg.dest_width});
        dh_s   = $signed({{(sbc_pkg::POS_W-SW){1'b0}}, cfg.dest_height});
        in_frame = (head.dc >= 0) && (head.dr >= 0) && (head.dc < dw_s) && (head.dr < dh_s);
        keyed  = cfg.key_enable && (head.pix == cfg.key_color);
        prod   = PROD_W'(head.dr[SW-1:0]) * PROD_W'(cfg.dest_width);
        sum    = prod + PROD_W'(head.dc[SW-1:0]);

        pop        = !empty && (!valid_reg || m_tready);
        valid_next = pop ? 1'b1 : (valid_reg && !m_tready);
        we_next    = in_frame && !keyed;
        addr_next  = we_next ? sum[sbc_pkg::ADDR_W-1:0] : '0;
        color_next = we_next ? head.pix : '0;
        last_next  = head.last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            we_reg    <= we_next;
            addr_reg  <= addr_next;
            color_reg <= color_next;
            last_reg  <= last_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {3'b000, color_reg, addr_reg, we_reg};
    assign m_tlast  = last_reg;

endmodule
`default_nettype wire

// ----- src/sprite_blit_clip_flip_colorkey_unit.sv -----
`default_nettype none
// Sprite blitter with clipping, horizontal and vertical mirroring and a color key.
//
// Input stream: tuser selects the word kind. A start word (tuser = 0) carries the
// placement and the mirror flags; it sets the sprite origin and restarts the raster
// counters, and it produces no output. A pixel word (tuser = 1) carries one source
// palette index in raster order and produces exactly one output word.
// Output stream: each word carries a framebuffer write enable, the address
// (row * dest_width + column), the color, and tlast on the last pixel of the sprite.
// Pixels that fall outside the framebuffer or match the enabled key color come out
// with the write enable low and zero address and color.
// Throughput is one input word per cycle while the sink is ready. An accepted pixel
// is written into the four-entry queue and from there moves into the output register,
// which drives the output stream.
// When the sink stalls, the output register holds its word and the queue absorbs up
// to four pixels before s_tready drops; while the queue is full, start words wait too.
// Reset (synchronous, active low) empties the queue and output register, zeroes the
// counters and the origin, clears the mirror flags and loads the register defaults.
// The APB port writes registers at byte address 4*i; write them only while idle.
module sprite_blit_clip_flip_colorkey_unit #(
    parameter int MAX_SIDE = sbc_pkg::MAX_SIDE_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Input stream: tdata = place_x[15:0], place_y[31:16], mirror_x[32], mirror_y[33],
    // pixel_value[41:34], zero[47:42]; tuser = cmd.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,
    input  wire logic        s_tuser,
    // Output stream: tdata = write_enable[0], write_address[20:1], write_color[28:21],
    // zero[31:29]; tlast = sprite_end.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,
    output logic             m_tlast,
    // Configuration port.
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [sbc_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [sbc_pkg::CFG_DATA_W-1:0] pwdata,
    output logic      [sbc_pkg::CFG_DATA_W-1:0] prdata,
    output logic                                pready
);

    localparam int SW = sbc_pkg::SIZE_W;
    localparam int CAP = (MAX_SIDE > 2047) ? 2047 : MAX_SIDE;
    localparam logic [SW-1:0] SIDE_CAP = SW'(CAP);

    sbc_pkg::cfg_t cfg_reg, cfg_next;
    sbc_pkg::reg_idx_t reg_idx;
    logic cfg_wr;

    logic          accept, push, pop, fifo_empty, fifo_full;
    sbc_pkg::pix_t push_entry, head;

    // Register file. Sizes are stored already clamped to one..cap.
    assign pready  = 1'b1;
    assign reg_idx = sbc_pkg::reg_idx_t'(paddr[4:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr) begin
            case (reg_idx)
                sbc_pkg::REG_SRC_WIDTH:   cfg_next.src_width   =
                    sbc_pkg::side_fix(pwdata[SW-1:0], SIDE_CAP);
                sbc_pkg::REG_SRC_HEIGHT:  cfg_next.src_height  =
                    sbc_pkg::side_fix(pwdata[SW-1:0], SIDE_CAP);
                sbc_pkg::REG_HOTSPOT_X:   cfg_next.hotspot_x   = pwdata[15:0];
                sbc_pkg::REG_HOTSPOT_Y:   cfg_next.hotspot_y   = pwdata[15:0];
                sbc_pkg::REG_KEY_ENABLE:  cfg_next.key_enable  = pwdata[0];
                sbc_pkg::REG_KEY_COLOR:   cfg_next.key_color   = pwdata[7:0];
                sbc_pkg::REG_DEST_WIDTH:  cfg_next.dest_width  =
                    sbc_pkg::side_fix(pwdata[SW-1:0], SIDE_CAP);
                sbc_pkg::REG_DEST_HEIGHT: cfg_next.dest_height =
                    sbc_pkg::side_fix(pwdata[SW-1:0], SIDE_CAP);
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            sbc_pkg::REG_SRC_WIDTH:   prdata = 32'(cfg_reg.src_width);
            sbc_pkg::REG_SRC_HEIGHT:  prdata = 32'(cfg_reg.src_height);
            sbc_pkg::REG_HOTSPOT_X:   prdata = 32'(cfg_reg.hotspot_x);
            sbc_pkg::REG_HOTSPOT_Y:   prdata = 32'(cfg_reg.hotspot_y);
            sbc_pkg::REG_KEY_ENABLE:  prdata = 32'(cfg_reg.key_enable);
            sbc_pkg::REG_KEY_COLOR:   prdata = 32'(cfg_reg.key_color);
            sbc_pkg::REG_DEST_WIDTH:  prdata = 32'(cfg_reg.dest_width);
            sbc_pkg::REG_DEST_HEIGHT: prdata = 32'(cfg_reg.dest_height);
            default:                  prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.src_width   <= SW'(1);
            cfg_reg.src_height  <= SW'(1);
            cfg_reg.hotspot_x   <= '0;
            cfg_reg.hotspot_y   <= '0;
            cfg_reg.key_enable  <= 1'b0;
            cfg_reg.key_color   <= '0;
            cfg_reg.dest_width  <= sbc_pkg::side_fix(SW'(1024), SIDE_CAP);
            cfg_reg.dest_height <= sbc_pkg::side_fix(SW'(1024), SIDE_CAP);
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // The front end takes a word whenever the queue has room.
    assign s_tready = !fifo_full;
    assign accept   = s_tvalid && s_tready;

    sbc_front #(
        .MAX_SIDE(MAX_SIDE)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .accept      (accept),
        .cmd         (s_tuser),
        .place_x     (s_tdata[15:0]),
        .place_y     (s_tdata[31:16]),
        .mirror_x    (s_tdata[32]),
        .mirror_y    (s_tdata[33]),
        .pixel_value (s_tdata[41:34]),
        .push        (push),
        .push_entry  (push_entry)
    );

    sbc_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .empty      (fifo_empty),
        .full       (fifo_full)
    );

    sbc_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .head     (head),
        .empty    (fifo_empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
`default_nettype wire
